FILE: hw/rtl/slpq_pkg.sv
// shared types, constants and helpers for the sorted list priority queue
`default_nettype none

package slpq_pkg;

    localparam int CAPACITY  = 16;
    localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int PTR_W     = $clog2(CAPACITY + 1);
    localparam int CNT_W     = PTR_W;
    localparam int DATA_W    = 32;
    localparam int OUT_CNT_W = 5;

    // null link is the first index past the store
    localparam logic [PTR_W-1:0] NIL = PTR_W'(CAPACITY);

    typedef enum logic {
        REQ_PUSH = 1'b0,
        REQ_POP  = 1'b1
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // walk continues while stored priority REL new priority
    typedef enum logic [1:0] {
        ORD_LE = 2'd0,
        ORD_LT = 2'd1,
        ORD_GE = 2'd2,
        ORD_GT = 2'd3
    } t_order;

    typedef struct packed {
        logic                     node_we;
        logic [IDX_W-1:0]         node_addr;
        logic signed [DATA_W-1:0] node_value;
        logic signed [DATA_W-1:0] node_priority;
        logic                     link_we;
        logic [IDX_W-1:0]         link_addr;
        logic [PTR_W-1:0]         link_data;
    } t_store_wr;

    function automatic logic is_node(input logic [PTR_W-1:0] ptr);
        return ptr < NIL;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/sorted_list_priority_queue_unit.sv
// top level: sequencer, list pointers and response register of the priority queue
`default_nettype none

// Priority queue held as a sorted singly linked list in a store of CAPACITY
// nodes (16), with unused nodes chained on a free list. A push request walks
// the list from the head, one node per clock through the single compare unit
// and the one read port of the node store, while the stored priority relates
// to the new one as order_mode says (0 <=, 1 <, 2 >=, 3 >, signed); the new
// node is then linked in where the walk stopped, so modes 0 and 2 keep equal
// priorities in arrival order. A pop request unlinks the head and returns it
// to the free list. Every request gives exactly one response with status,
// popped element, new top and count. A push walks the list serially over
// the read port and then links the node in; a successful pop reads the old
// head's link, then the new head's data. The block takes one request at a
// time and is not ready while one is in progress; the response sits in an
// output register, so a new request is taken while the previous response
// still waits. order_mode is written through i_cfg_we / i_cfg_wdata and
// must only change when idle.
module sorted_list_priority_queue_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration
    input  logic                                  i_cfg_we,
    input  logic [1:0]                            i_cfg_wdata,
    // request channel
    input  logic                                  i_req_valid,
    output logic                                  o_req_ready,
    input  logic                                  i_req_type,
    input  logic signed [slpq_pkg::DATA_W-1:0]    i_item_value,
    input  logic signed [slpq_pkg::DATA_W-1:0]    i_item_priority,
    // response channel
    output logic                                  o_rsp_valid,
    input  logic                                  i_rsp_ready,
    output logic [1:0]                            o_status,
    output logic signed [slpq_pkg::DATA_W-1:0]    o_popped_value,
    output logic signed [slpq_pkg::DATA_W-1:0]    o_popped_priority,
    output logic                                  o_top_valid,
    output logic signed [slpq_pkg::DATA_W-1:0]    o_top_value,
    output logic signed [slpq_pkg::DATA_W-1:0]    o_top_priority,
    output logic [slpq_pkg::OUT_CNT_W-1:0]        o_entry_count
);
    import slpq_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_WALK  = 7'b0000010,
        S_LINK1 = 7'b0000100,
        S_LINK2 = 7'b0001000,
        S_POP1  = 7'b0010000,
        S_POP2  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    // sequencer and list state
    t_state                   r_state, n_state;
    t_order                   r_order_mode;
    logic [PTR_W-1:0]         r_list_head, n_list_head;
    logic [PTR_W-1:0]         r_free_head, n_free_head;
    logic [CNT_W-1:0]         r_count, n_count;
    logic                     r_top_valid, n_top_valid;
    logic signed [DATA_W-1:0] r_top_value, n_top_value;
    logic signed [DATA_W-1:0] r_top_priority, n_top_priority;

    // working registers of the request in progress
    logic signed [DATA_W-1:0] r_item_value, n_item_value;
    logic signed [DATA_W-1:0] r_item_priority, n_item_priority;
    logic [PTR_W-1:0]         r_prev, n_prev;
    logic [PTR_W-1:0]         r_cur, n_cur;
    logic [PTR_W-1:0]         r_steps, n_steps;
    t_status                  r_status, n_status;
    logic signed [DATA_W-1:0] r_pop_value, n_pop_value;
    logic signed [DATA_W-1:0] r_pop_priority, n_pop_priority;

    // response register
    logic                     r_rsp_valid, n_rsp_valid;
    logic                     rsp_load;
    t_status                  r_o_status;
    logic signed [DATA_W-1:0] r_o_pop_value;
    logic signed [DATA_W-1:0] r_o_pop_priority;
    logic                     r_o_top_valid;
    logic signed [DATA_W-1:0] r_o_top_value;
    logic signed [DATA_W-1:0] r_o_top_priority;
    logic [OUT_CNT_W-1:0]     r_o_count;

    // node store and compare unit
    t_store_wr                store_wr;
    logic [IDX_W-1:0]         rd_addr;
    logic signed [DATA_W-1:0] rd_value;
    logic signed [DATA_W-1:0] rd_priority;
    logic [PTR_W-1:0]         rd_link;
    logic                     rel_holds;

    slpq_store u_store (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_wr          (store_wr),
        .i_rd_addr     (rd_addr),
        .o_rd_value    (rd_value),
        .o_rd_priority (rd_priority),
        .o_rd_link     (rd_link)
    );

    // stored priority of the node being walked against the new one
    slpq_rel u_rel (
        .i_mode   (r_order_mode),
        .i_stored (rd_priority),
        .i_fresh  (r_item_priority),
        .o_holds  (rel_holds)
    );

    assign o_req_ready = (r_state == S_IDLE);

    always_comb begin
        n_state         = r_state;
        n_list_head     = r_list_head;
        n_free_head     = r_free_head;
        n_count         = r_count;
        n_top_valid     = r_top_valid;
        n_top_value     = r_top_value;
        n_top_priority  = r_top_priority;
        n_item_value    = r_item_value;
        n_item_priority = r_item_priority;
        n_prev          = r_prev;
        n_cur           = r_cur;
        n_steps         = r_steps;
        n_status        = r_status;
        n_pop_value     = r_pop_value;
        n_pop_priority  = r_pop_priority;
        rsp_load        = 1'b0;
        store_wr        = '0;
        // idle reads the head, so a walk or pop finds its data next cycle
        rd_addr         = r_list_head[IDX_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_item_value    = i_item_value;
                    n_item_priority = i_item_priority;
                    n_pop_value     = '0;
                    n_pop_priority  = '0;
                    n_status        = ST_OK;
                    if (i_req_type == REQ_PUSH) begin
                        if (r_count >= CNT_W'(CAPACITY) || !is_node(r_free_head)) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_prev  = NIL;
                            n_cur   = r_list_head;
                            n_steps = '0;
                            n_state = is_node(r_list_head) ? S_WALK : S_LINK1;
                        end
                    end else begin
                        if (!is_node(r_list_head) || r_count == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            n_cur   = r_list_head;
                            n_state = S_POP1;
                        end
                    end
                end
            end

            S_WALK: begin
                // read data belongs to r_cur; fetch its successor meanwhile
                rd_addr = rd_link[IDX_W-1:0];
                if (r_steps == PTR_W'(CAPACITY)) begin
                    n_state = S_LINK1;
                end else if (rel_holds) begin
                    n_prev  = r_cur;
                    n_cur   = rd_link;
                    n_steps = r_steps + PTR_W'(1);
                    n_state = is_node(rd_link) ? S_WALK : S_LINK1;
                end else begin
                    n_state = S_LINK1;
                end
            end

            S_LINK1: begin
                // fetch the free node's successor, hook predecessor to the free node
                rd_addr = r_free_head[IDX_W-1:0];
                if (is_node(r_prev)) begin
                    store_wr.link_we   = 1'b1;
                    store_wr.link_addr = r_prev[IDX_W-1:0];
                    store_wr.link_data = r_free_head;
                end
                n_state = S_LINK2;
            end

            S_LINK2: begin
                store_wr.node_we       = 1'b1;
                store_wr.node_addr     = r_free_head[IDX_W-1:0];
                store_wr.node_value    = r_item_value;
                store_wr.node_priority = r_item_priority;
                store_wr.link_we       = 1'b1;
                store_wr.link_addr     = r_free_head[IDX_W-1:0];
                store_wr.link_data     = is_node(r_cur) ? r_cur : NIL;
                n_free_head = is_node(rd_link) ? rd_link : NIL;
                if (!is_node(r_prev)) begin
                    n_list_head    = r_free_head;
                    n_top_valid    = 1'b1;
                    n_top_value    = r_item_value;
                    n_top_priority = r_item_priority;
                end
                n_count = r_count + CNT_W'(1);
                n_state = S_DONE;
            end

            S_POP1: begin
                // rd_link is the old head's successor; read the new head's data
                rd_addr            = rd_link[IDX_W-1:0];
                n_list_head        = is_node(rd_link) ? rd_link : NIL;
                store_wr.link_we   = 1'b1;
                store_wr.link_addr = r_cur[IDX_W-1:0];
                store_wr.link_data = r_free_head;
                n_free_head        = r_cur;
                n_count            = r_count - CNT_W'(1);
                n_pop_value        = r_top_value;
                n_pop_priority     = r_top_priority;
                n_state            = S_POP2;
            end

            S_POP2: begin
                if (is_node(r_list_head)) begin
                    n_top_valid    = 1'b1;
                    n_top_value    = rd_value;
                    n_top_priority = rd_priority;
                end else begin
                    n_top_valid    = 1'b0;
                    n_top_value    = '0;
                    n_top_priority = '0;
                end
                n_state = S_DONE;
            end

            S_DONE: begin
                // wait only while the previous response is still held
                if (!r_rsp_valid || i_rsp_ready) begin
                    rsp_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_rsp_valid = r_rsp_valid;
        if (rsp_load) begin
            n_rsp_valid = 1'b1;
        end else if (i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_list_head <= NIL;
            r_free_head <= '0;
            r_count     <= '0;
            r_top_valid <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_list_head <= n_list_head;
            r_free_head <= n_free_head;
            r_count     <= n_count;
            r_top_valid <= n_top_valid;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    // ordering register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order_mode <= ORD_LE;
        end else if (i_cfg_we) begin
            r_order_mode <= t_order'(i_cfg_wdata);
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_top_value     <= n_top_value;
        r_top_priority  <= n_top_priority;
        r_item_value    <= n_item_value;
        r_item_priority <= n_item_priority;
        r_prev          <= n_prev;
        r_cur           <= n_cur;
        r_steps         <= n_steps;
        r_status        <= n_status;
        r_pop_value     <= n_pop_value;
        r_pop_priority  <= n_pop_priority;
        if (rsp_load) begin
            r_o_status       <= r_status;
            r_o_pop_value    <= r_pop_value;
            r_o_pop_priority <= r_pop_priority;
            r_o_top_valid    <= r_top_valid;
            // empty queue reports a zero top
            r_o_top_value    <= r_top_valid ? r_top_value : '0;
            r_o_top_priority <= r_top_valid ? r_top_priority : '0;
            r_o_count        <= OUT_CNT_W'(r_count);
        end
    end

    assign o_rsp_valid       = r_rsp_valid;
    assign o_status          = r_o_status;
    assign o_popped_value    = r_o_pop_value;
    assign o_popped_priority = r_o_pop_priority;
    assign o_top_valid       = r_o_top_valid;
    assign o_top_value       = r_o_top_value;
    assign o_top_priority    = r_o_top_priority;
    assign o_entry_count     = r_o_count;

endmodule

`default_nettype wire

FILE: hw/rtl/slpq_rel.sv
// priority compare unit shared by every step of the list walk
`default_nettype none

module slpq_rel (
    input  slpq_pkg::t_order                          i_mode,
    input  logic signed [slpq_pkg::DATA_W-1:0]        i_stored,
    input  logic signed [slpq_pkg::DATA_W-1:0]        i_fresh,
    output logic                                      o_holds
);
    import slpq_pkg::*;

    always_comb begin
        case (i_mode)
            ORD_LE:  o_holds = (i_stored <= i_fresh);
            ORD_LT:  o_holds = (i_stored <  i_fresh);
            ORD_GE:  o_holds = (i_stored >= i_fresh);
            ORD_GT:  o_holds = (i_stored >  i_fresh);
            default: o_holds = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/slpq_store.sv
// node store: value, priority and link memories with registered read
`default_nettype none

module slpq_store (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  slpq_pkg::t_store_wr                  i_wr,
    input  logic [slpq_pkg::IDX_W-1:0]           i_rd_addr,
    output logic signed [slpq_pkg::DATA_W-1:0]   o_rd_value,
    output logic signed [slpq_pkg::DATA_W-1:0]   o_rd_priority,
    output logic [slpq_pkg::PTR_W-1:0]           o_rd_link
);
    import slpq_pkg::*;

    logic signed [DATA_W-1:0] r_value_mem [CAPACITY];
    logic signed [DATA_W-1:0] r_prio_mem  [CAPACITY];
    logic [PTR_W-1:0]         r_link_mem  [CAPACITY];
    logic [CAPACITY-1:0]      r_link_vld;

    logic signed [DATA_W-1:0] r_rd_value;
    logic signed [DATA_W-1:0] r_rd_priority;
    logic [PTR_W-1:0]         r_rd_link;
    logic                     r_rd_vld;
    logic [IDX_W-1:0]         r_rd_addr;

    always_ff @(posedge i_clk) begin
        if (i_wr.node_we) begin
            r_value_mem[i_wr.node_addr] <= i_wr.node_value;
            r_prio_mem[i_wr.node_addr]  <= i_wr.node_priority;
        end
        if (i_wr.link_we) begin
            r_link_mem[i_wr.link_addr] <= i_wr.link_data;
        end
        r_rd_value    <= r_value_mem[i_rd_addr];
        r_rd_priority <= r_prio_mem[i_rd_addr];
        r_rd_link     <= r_link_mem[i_rd_addr];
        r_rd_vld      <= r_link_vld[i_rd_addr];
        r_rd_addr     <= i_rd_addr;
    end

    // unwritten link entries read as the reset free chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_vld <= '0;
        end else if (i_wr.link_we) begin
            r_link_vld[i_wr.link_addr] <= 1'b1;
        end
    end

    assign o_rd_value    = r_rd_value;
    assign o_rd_priority = r_rd_priority;
    assign o_rd_link     = r_rd_vld ? r_rd_link : (PTR_W'(r_rd_addr) + PTR_W'(1));

endmodule

`default_nettype wire

FILE: tb/slpq_checker.sv
// checker for the sorted list priority queue: predicts every response and compares it
`default_nettype none

module slpq_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [1:0]                         i_cfg_wdata,
    input  logic                               i_req_valid,
    input  logic                               i_req_ready,
    input  logic                               i_req_type,
    input  logic signed [slpq_pkg::DATA_W-1:0] i_item_value,
    input  logic signed [slpq_pkg::DATA_W-1:0] i_item_priority,
    input  logic                               i_rsp_valid,
    input  logic                               i_rsp_ready,
    input  logic [1:0]                         i_status,
    input  logic signed [slpq_pkg::DATA_W-1:0] i_popped_value,
    input  logic signed [slpq_pkg::DATA_W-1:0] i_popped_priority,
    input  logic                               i_top_valid,
    input  logic signed [slpq_pkg::DATA_W-1:0] i_top_value,
    input  logic signed [slpq_pkg::DATA_W-1:0] i_top_priority,
    input  logic [slpq_pkg::OUT_CNT_W-1:0]     i_entry_count,
    output int                                 o_fail_count,
    output int                                 o_rsp_count,
    output int                                 o_pending
);
    import slpq_pkg::*;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] prio;
    } t_entry;

    typedef struct {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] popped_value;
        logic signed [DATA_W-1:0] popped_prio;
        logic                     top_valid;
        logic signed [DATA_W-1:0] top_value;
        logic signed [DATA_W-1:0] top_prio;
        logic [OUT_CNT_W-1:0]     count;
    } t_queue_result;

    // queue contents, head first
    t_entry        queue_image[$];
    t_queue_result pending_results[$];
    t_order        order_sel = ORD_LE;
    int            fail_total = 0;
    int            rsp_total = 0;
    t_queue_result got;
    t_queue_result want;

    function automatic bit walk_goes_on(input logic signed [DATA_W-1:0] stored,
                                        input logic signed [DATA_W-1:0] fresh);
        case (order_sel)
            ORD_LE:  return stored <= fresh;
            ORD_LT:  return stored < fresh;
            ORD_GE:  return stored >= fresh;
            default: return stored > fresh;
        endcase
    endfunction

    function automatic t_queue_result apply_request(input t_req kind,
                                                    input logic signed [DATA_W-1:0] value,
                                                    input logic signed [DATA_W-1:0] prio);
        t_queue_result r;
        t_entry        e;
        int            pos;
        r.status       = ST_OK;
        r.popped_value = '0;
        r.popped_prio  = '0;
        if (kind == REQ_PUSH) begin
            if (queue_image.size() >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                pos = 0;
                while (pos < queue_image.size() && walk_goes_on(queue_image[pos].prio, prio))
                    pos++;
                e.value = value;
                e.prio  = prio;
                queue_image.insert(pos, e);
            end
        end else begin
            if (queue_image.size() == 0) begin
                r.status = ST_EMPTY;
            end else begin
                e = queue_image.pop_front();
                r.popped_value = e.value;
                r.popped_prio  = e.prio;
            end
        end
        r.top_valid = (queue_image.size() != 0);
        r.top_value = r.top_valid ? queue_image[0].value : '0;
        r.top_prio  = r.top_valid ? queue_image[0].prio : '0;
        r.count     = OUT_CNT_W'(queue_image.size());
        return r;
    endfunction

    function automatic bit results_differ(input t_queue_result a, input t_queue_result b);
        return (a.status !== b.status) || (a.popped_value !== b.popped_value) ||
               (a.popped_prio !== b.popped_prio) || (a.top_valid !== b.top_valid) ||
               (a.top_value !== b.top_value) || (a.top_prio !== b.top_prio) ||
               (a.count !== b.count);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            queue_image.delete();
            pending_results.delete();
            order_sel = ORD_LE;
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                rsp_total++;
                got.status       = i_status;
                got.popped_value = i_popped_value;
                got.popped_prio  = i_popped_priority;
                got.top_valid    = i_top_valid;
                got.top_value    = i_top_value;
                got.top_prio     = i_top_priority;
                got.count        = i_entry_count;
                if (pending_results.size() == 0) begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("%0t: response %0d with nothing expected", $realtime,
                                 rsp_total);
                end else begin
                    want = pending_results.pop_front();
                    if (results_differ(got, want)) begin
                        fail_total++;
                        if (fail_total <= 10) begin
                            $display("%0t: response %0d mismatch", $realtime, rsp_total);
                            $display("  exp st %0d pop %0d/%0d top %0b %0d/%0d cnt %0d",
                                     want.status, want.popped_value, want.popped_prio,
                                     want.top_valid, want.top_value, want.top_prio,
                                     want.count);
                            $display("  got st %0d pop %0d/%0d top %0b %0d/%0d cnt %0d",
                                     got.status, got.popped_value, got.popped_prio,
                                     got.top_valid, got.top_value, got.top_prio,
                                     got.count);
                        end
                    end
                end
            end
            if (i_cfg_we)
                order_sel = t_order'(i_cfg_wdata);
            if (i_req_valid && i_req_ready)
                pending_results.push_back(apply_request(t_req'(i_req_type), i_item_value,
                                                        i_item_priority));
        end
        o_fail_count <= fail_total;
        o_rsp_count  <= rsp_total;
        o_pending    <= pending_results.size();
    end

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// top of the priority queue testbench: clock, reset, request stimulus and verdict
`default_nettype none

module tb_top;
    import slpq_pkg::*;

    // every block input starts at a known value
    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [1:0]               i_cfg_wdata = 2'd0;
    logic                     i_req_valid = 1'b0;
    logic                     i_req_type = 1'b0;
    logic signed [DATA_W-1:0] i_item_value = '0;
    logic signed [DATA_W-1:0] i_item_priority = '0;
    logic                     i_rsp_ready = 1'b0;

    logic                     o_req_ready;
    logic                     o_rsp_valid;
    logic [1:0]               o_status;
    logic signed [DATA_W-1:0] o_popped_value;
    logic signed [DATA_W-1:0] o_popped_priority;
    logic                     o_top_valid;
    logic signed [DATA_W-1:0] o_top_value;
    logic signed [DATA_W-1:0] o_top_priority;
    logic [OUT_CNT_W-1:0]     o_entry_count;

    int fail_count;
    int rsp_count;
    int pending_count;
    int sent_count = 0;
    // when set neither side idles
    bit calm = 1'b0;

    sorted_list_priority_queue_unit uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_req_valid       (i_req_valid),
        .o_req_ready       (o_req_ready),
        .i_req_type        (i_req_type),
        .i_item_value      (i_item_value),
        .i_item_priority   (i_item_priority),
        .o_rsp_valid       (o_rsp_valid),
        .i_rsp_ready       (i_rsp_ready),
        .o_status          (o_status),
        .o_popped_value    (o_popped_value),
        .o_popped_priority (o_popped_priority),
        .o_top_valid       (o_top_valid),
        .o_top_value       (o_top_value),
        .o_top_priority    (o_top_priority),
        .o_entry_count     (o_entry_count)
    );

    slpq_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_req_valid       (i_req_valid),
        .i_req_ready       (o_req_ready),
        .i_req_type        (i_req_type),
        .i_item_value      (i_item_value),
        .i_item_priority   (i_item_priority),
        .i_rsp_valid       (o_rsp_valid),
        .i_rsp_ready       (i_rsp_ready),
        .i_status          (o_status),
        .i_popped_value    (o_popped_value),
        .i_popped_priority (o_popped_priority),
        .i_top_valid       (o_top_valid),
        .i_top_value       (o_top_value),
        .i_top_priority    (o_top_priority),
        .i_entry_count     (o_entry_count),
        .o_fail_count      (fail_count),
        .o_rsp_count       (rsp_count),
        .o_pending         (pending_count)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // response side: stalls about 13 percent of the time unless calm
    always @(posedge i_clk) begin
        if (calm)
            i_rsp_ready <= 1'b1;
        else
            i_rsp_ready <= ($urandom_range(99) >= 13);
    end

    // offer one request and hold it until the block takes it; an optional
    // gap with valid low goes in front, never between acceptance and reuse
    task automatic send_request(input t_req kind, input logic signed [DATA_W-1:0] value,
                                input logic signed [DATA_W-1:0] prio);
        if (!calm && $urandom_range(99) < 13) begin
            i_req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_req_valid     <= 1'b1;
        i_req_type      <= kind;
        i_item_value    <= value;
        i_item_priority <= prio;
        @(posedge i_clk);
        while (!o_req_ready) @(posedge i_clk);
        sent_count++;
    endtask

    // stop offering and wait for every response; rsp_count is registered and
    // lags, which only makes the wait longer
    task automatic drain;
        i_req_valid <= 1'b0;
        while (rsp_count != sent_count) @(posedge i_clk);
    endtask

    // order mode only changes with the block idle
    task automatic write_order(input t_order mode);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mode;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // priorities lean on a handful of values so ties and extremes are common
    function automatic logic signed [DATA_W-1:0] pick_priority();
        case ($urandom_range(3))
            0: return $urandom;
            1: return int'($urandom_range(4)) - 2;
            2: begin
                case ($urandom_range(3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7fff_ffff;
                    2: return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            default: return int'($urandom_range(15)) * 1000 - 8000;
        endcase
    endfunction

    // a run of requests with a given share of pushes, so the list swings
    // between empty and full
    task automatic random_burst(input int n, input int push_pct);
        int   k;
        t_req kind;
        for (k = 0; k < n; k++) begin
            kind = ($urandom_range(99) < push_pct) ? REQ_PUSH : REQ_POP;
            send_request(kind, $urandom, pick_priority());
        end
    endtask

    // ends a hung run
    initial begin
        #2_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    initial begin
        t_order modes[8];
        int     shares[4];
        int     ph;
        int     b;
        int     k;
        modes  = '{ORD_GT, ORD_LT, ORD_GE, ORD_LE, ORD_GT, ORD_GE, ORD_LT, ORD_LE};
        shares = '{30, 50, 70, 90};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part in reset order mode (stored <= new)
        // pop on an empty queue is refused
        send_request(REQ_POP, 32'sh7fff_ffff, 32'sh8000_0000);
        // priority extremes, a tie kept in arrival order, negative priority
        send_request(REQ_PUSH, 32'sh8000_0000, 32'sh7fff_ffff);
        send_request(REQ_PUSH, 32'sh7fff_ffff, 32'sh8000_0000);
        send_request(REQ_PUSH, -32'sd1, 32'sd0);
        send_request(REQ_PUSH, 32'sd5, 32'sd0);
        send_request(REQ_PUSH, 32'sd0, -32'sd1);
        // fill the store, then one push too many is refused
        for (k = 0; k < CAPACITY - 5; k++)
            send_request(REQ_PUSH, $urandom, int'($urandom_range(6)) - 3);
        send_request(REQ_PUSH, 32'sh1234_5678, 32'sd0);
        // pops come off in sorted order
        for (k = 0; k < 5; k++)
            send_request(REQ_POP, $urandom, $urandom);

        // random part: one order mode per phase, all four modes used
        for (ph = 0; ph < 8; ph++) begin
            write_order(modes[ph]);
            // one whole phase without idling on either side
            calm <= (ph == 4);
            for (b = 0; b < 4; b++)
                random_burst(40, shares[$urandom_range(3)]);
        end

        drain();
        // allow for a stray response after the last one expected
        repeat (30) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
